// ===== rtl/emst_pkg.sv =====
package emst_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FIELD_W = 16;
  localparam int THR_W   = 17;
  localparam int GRP_W   = 11;
  localparam int LEN_W   = 27;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_ORIGIN,
    S_ORIGIN_WAIT,
    S_PASS,
    S_MARK,
    S_SQRT,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/emst_if.sv =====
interface emst_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [emst_pkg::FIELD_W-1:0] x_coord;
  logic signed [emst_pkg::FIELD_W-1:0] y_coord;
  logic                                last_point;

  modport source (output valid, x_coord, y_coord, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

interface emst_out_if;
  logic                              valid;
  logic                              ready;
  logic [emst_pkg::GRP_W-1:0]        group_count;
  logic [emst_pkg::LEN_W-1:0]        road_length;
  logic [emst_pkg::LEN_W-1:0]        railroad_length;
  logic                              overflow;

  modport source (output valid, group_count, road_length, railroad_length, overflow,
                  input ready);
  modport sink   (input valid, group_count, road_length, railroad_length, overflow,
                  output ready);
endinterface

// ===== rtl/euclidean_mst_threshold_split.sv =====
// Euclidean minimum spanning tree with a threshold split.
// Points arrive on the pt channel, one request per cycle, and are stored in
// on-chip memory. A request with last_point high stores its point and starts
// the tree build (Prim); pt.ready stays low until the result is formed.
// Tree edges at or above the threshold register count as railroad edges.
// The res channel carries one request per set: group_count, the rounded road
// and railroad lengths, and overflow when points past capacity were dropped.
// For n >= 2 stored points the build adds n - 1 tree edges; a single point
// goes straight to the result. Each tree edge costs one sweep over the point
// and distance memories, one mark state and the one-bit-per-cycle square root
// unit of ROOT_W = (2 * COORD_BITS + 1 + 2 * FRAC_BITS + 1) / 2 steps.
// The threshold is written through cfg_we / cfg_wdata while idle.
// Reset clears the point count, sums and the threshold; memories need no
// clearing. A stalled receiver holds the result; loading of the next set
// proceeds; a following build runs, then waits until the old result is taken.
module euclidean_mst_threshold_split #(
  parameter int MAX_POINTS = emst_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = emst_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = emst_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [emst_pkg::THR_W-1:0] cfg_wdata,
  emst_in_if.sink                    pt,
  emst_out_if.source                 res
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int C      = COORD_BITS;
  localparam int D2W    = 2 * C + 1;
  localparam int ROOT_W = (D2W + 2 * FRAC_BITS + 1) / 2;
  localparam int SUMW   = ROOT_W + CW;
  localparam int TSQW   = 2 * emst_pkg::THR_W;
  localparam int CMPW   = (D2W > TSQW) ? D2W : TSQW;
  localparam int FW     = emst_pkg::FIELD_W;
  localparam int GW     = emst_pkg::GRP_W;
  localparam int LW     = emst_pkg::LEN_W;

  emst_pkg::state_t state, state_next;

  logic [emst_pkg::THR_W-1:0] thr;
  logic [TSQW-1:0]            thr_sq;
  logic [CW-1:0]              count;
  logic [CW-1:0]              n;
  logic                       dropped;
  logic [CW-1:0]              edges;
  logic [GW-1:0]              rail_edges;
  logic [SUMW-1:0]            road_sum;
  logic [SUMW-1:0]            rail_sum;
  logic                       cur_rail;
  logic                       first;
  logic [C-1:0]               px;
  logic [C-1:0]               py;

  logic [AW-1:0]  idx;
  logic           issuing;
  logic           p1_v;
  logic [AW-1:0]  p1_a;
  logic           p2_v;
  logic [AW-1:0]  p2_a;
  logic [C-1:0]   p2_dx;
  logic [C-1:0]   p2_dy;
  logic           p2_bf;
  logic [D2W-1:0] p2_bv;
  logic           p3_v;
  logic [AW-1:0]  p3_a;
  logic [2*C-1:0] p3_sx;
  logic [2*C-1:0] p3_sy;
  logic           p3_bf;
  logic [D2W-1:0] p3_bv;
  logic           min_v;
  logic [AW-1:0]  min_a;
  logic [D2W-1:0] min_d;

  logic           res_v;
  logic [GW-1:0]  res_grp;
  logic [LW-1:0]  res_road;
  logic [LW-1:0]  res_rail;
  logic           res_ovf;

  logic           xy_we;
  logic [AW-1:0]  xy_waddr;
  logic [AW-1:0]  xy_raddr;
  logic [C-1:0]   x_in;
  logic [C-1:0]   y_in;
  logic [C-1:0]   x_rd;
  logic [C-1:0]   y_rd;
  logic           b_we;
  logic [AW-1:0]  b_waddr;
  logic [D2W:0]   b_wdata;
  logic [D2W:0]   b_rd;

  logic             sq_start;
  logic             sq_done;
  logic [ROOT_W-1:0] sq_root;

  logic [C+FW-1:0] x_ext;
  logic [C+FW-1:0] y_ext;
  logic            pt_acc;
  logic [CW-1:0]   count_next;
  logic            pass_done;
  logic            out_free;
  logic            p3_in;
  logic [D2W-1:0]  nd;
  logic [D2W-1:0]  new_d;
  logic [C:0]      dx_s;
  logic [C:0]      dy_s;
  logic [C:0]      dx_a;
  logic [C:0]      dy_a;
  logic [SUMW:0]   road_rnd;
  logic [SUMW:0]   rail_rnd;
  logic            last_edge;

  assign x_ext  = {{C{1'b0}}, pt.x_coord};
  assign y_ext  = {{C{1'b0}}, pt.y_coord};
  assign x_in   = x_ext[C-1:0];
  assign y_in   = y_ext[C-1:0];
  assign pt.ready = (state == emst_pkg::S_LOAD);
  assign pt_acc = pt.valid && pt.ready;
  assign count_next = (count < CW'(MAX_POINTS)) ? count + 1'b1 : count;
  assign pass_done = !issuing && !p1_v && !p2_v && !p3_v;
  assign out_free  = !res_v || res.ready;
  assign last_edge = (edges + 1'b1 == n - 1'b1);

  assign res.valid           = res_v;
  assign res.group_count     = res_grp;
  assign res.road_length     = res_road;
  assign res.railroad_length = res_rail;
  assign res.overflow        = res_ovf;

  assign dx_s = $signed({x_rd[C-1], x_rd}) - $signed({px[C-1], px});
  assign dy_s = $signed({y_rd[C-1], y_rd}) - $signed({py[C-1], py});
  assign dx_a = dx_s[C] ? -dx_s : dx_s;
  assign dy_a = dy_s[C] ? -dy_s : dy_s;

  assign nd    = D2W'(p3_sx) + D2W'(p3_sy);
  assign p3_in = p3_bf && !first;
  assign new_d = (first || nd < p3_bv) ? nd : p3_bv;

  always_comb begin
    road_rnd = ((SUMW + 1)'(road_sum) + (SUMW + 1)'(2 ** (FRAC_BITS - 1))) >> FRAC_BITS;
    rail_rnd = ((SUMW + 1)'(rail_sum) + (SUMW + 1)'(2 ** (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  emst_ram #(.WIDTH(C), .DEPTH(MAX_POINTS)) u_x_mem (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(x_in), .raddr(xy_raddr), .rdata(x_rd)
  );

  emst_ram #(.WIDTH(C), .DEPTH(MAX_POINTS)) u_y_mem (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(y_in), .raddr(xy_raddr), .rdata(y_rd)
  );

  emst_ram #(.WIDTH(D2W + 1), .DEPTH(MAX_POINTS)) u_best_mem (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(xy_raddr), .rdata(b_rd)
  );

  emst_sqrt #(.IN_W(D2W), .FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(min_d), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      emst_pkg::S_LOAD: begin
        if (pt_acc && pt.last_point) begin
          state_next = emst_pkg::S_START;
        end
      end
      emst_pkg::S_START: begin
        state_next = (n <= CW'(1)) ? emst_pkg::S_FINISH : emst_pkg::S_ORIGIN;
      end
      emst_pkg::S_ORIGIN:      state_next = emst_pkg::S_ORIGIN_WAIT;
      emst_pkg::S_ORIGIN_WAIT: state_next = emst_pkg::S_PASS;
      emst_pkg::S_PASS: begin
        if (pass_done) begin
          state_next = emst_pkg::S_MARK;
        end
      end
      emst_pkg::S_MARK: state_next = emst_pkg::S_SQRT;
      emst_pkg::S_SQRT: begin
        if (sq_done) begin
          state_next = last_edge ? emst_pkg::S_FINISH : emst_pkg::S_PASS;
        end
      end
      emst_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = emst_pkg::S_LOAD;
        end
      end
      default: state_next = emst_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    xy_we    = 1'b0;
    xy_waddr = count[AW-1:0];
    xy_raddr = idx;
    b_we     = 1'b0;
    b_waddr  = p3_a;
    b_wdata  = {1'b0, new_d};
    sq_start = 1'b0;
    unique case (state)
      emst_pkg::S_LOAD: begin
        xy_we = pt_acc && (count < CW'(MAX_POINTS));
      end
      emst_pkg::S_ORIGIN: xy_raddr = '0;
      emst_pkg::S_PASS: begin
        b_we = p3_v && !p3_in;
      end
      emst_pkg::S_MARK: begin
        xy_raddr = min_a;
        b_we     = 1'b1;
        b_waddr  = min_a;
        b_wdata  = {1'b1, min_d};
        sq_start = 1'b1;
      end
      emst_pkg::S_SQRT: xy_raddr = min_a;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= emst_pkg::S_LOAD;
      thr        <= '0;
      count      <= '0;
      dropped    <= 1'b0;
      rail_edges <= '0;
      road_sum   <= '0;
      rail_sum   <= '0;
      issuing    <= 1'b0;
      p1_v       <= 1'b0;
      p2_v       <= 1'b0;
      p3_v       <= 1'b0;
      min_v      <= 1'b0;
      res_v      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (res_v && res.ready && (state != emst_pkg::S_FINISH)) begin
        res_v <= 1'b0;
      end

      p1_v <= (state == emst_pkg::S_PASS) && issuing;
      p1_a <= idx;
      p2_v <= p1_v;
      p2_a <= p1_a;
      p2_dx <= dx_a[C-1:0];
      p2_dy <= dy_a[C-1:0];
      p2_bf <= b_rd[D2W];
      p2_bv <= b_rd[D2W-1:0];
      p3_v <= p2_v;
      p3_a <= p2_a;
      p3_sx <= p2_dx * p2_dx;
      p3_sy <= p2_dy * p2_dy;
      p3_bf <= p2_bf;
      p3_bv <= p2_bv;

      unique case (state)
        emst_pkg::S_LOAD: begin
          if (pt_acc) begin
            count <= count_next;
            if (count >= CW'(MAX_POINTS)) begin
              dropped <= 1'b1;
            end
            n <= count_next;
          end
        end
        emst_pkg::S_START: begin
          thr_sq <= thr * thr;
          edges  <= '0;
        end
        emst_pkg::S_ORIGIN_WAIT: begin
          px      <= x_rd;
          py      <= y_rd;
          first   <= 1'b1;
          idx     <= AW'(1);
          issuing <= 1'b1;
          min_v   <= 1'b0;
        end
        emst_pkg::S_PASS: begin
          if (issuing) begin
            if (CW'(idx) == n - 1'b1) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (p3_v && !p3_in && (!min_v || new_d < min_d)) begin
            min_v <= 1'b1;
            min_a <= p3_a;
            min_d <= new_d;
          end
        end
        emst_pkg::S_MARK: begin
          first    <= 1'b0;
          cur_rail <= CMPW'(min_d) >= CMPW'(thr_sq);
        end
        emst_pkg::S_SQRT: begin
          if (sq_done) begin
            px    <= x_rd;
            py    <= y_rd;
            edges <= edges + 1'b1;
            if (cur_rail) begin
              rail_edges <= rail_edges + 1'b1;
              rail_sum   <= rail_sum + SUMW'(sq_root);
            end else begin
              road_sum <= road_sum + SUMW'(sq_root);
            end
            idx     <= AW'(1);
            issuing <= !last_edge;
            min_v   <= 1'b0;
          end
        end
        emst_pkg::S_FINISH: begin
          if (out_free) begin
            res_v    <= 1'b1;
            res_grp  <= rail_edges + 1'b1;
            res_road <= (road_rnd > (SUMW + 1)'(2 ** LW - 1)) ? {LW{1'b1}} : LW'(road_rnd);
            res_rail <= (rail_rnd > (SUMW + 1)'(2 ** LW - 1)) ? {LW{1'b1}} : LW'(rail_rnd);
            res_ovf  <= dropped;
            count      <= '0;
            dropped    <= 1'b0;
            rail_edges <= '0;
            road_sum   <= '0;
            rail_sum   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/emst_ram.sv =====
module emst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/emst_sqrt.sv =====
module emst_sqrt #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = emst_pkg::FRAC_BITS_DEF,
  parameter int ROOT_W    = (IN_W + 2 * FRAC_BITS + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;

  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= RAD_W'({radicand, {(2 * FRAC_BITS){1'b0}}});
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ===== dv/emst_checker.sv =====
module emst_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [emst_pkg::THR_W-1:0] cfg_wdata,
  emst_in_if                         pt,
  emst_out_if                        res,
  output int                         fail_count,
  output int                         pending
);
  import emst_pkg::*;

  localparam int CAP = MAX_POINTS_DEF;

  typedef struct {
    logic [GRP_W-1:0] groups;
    logic [LEN_W-1:0] road;
    logic [LEN_W-1:0] rail;
    logic             ovf;
  } tally_t;

  tally_t             tally_q[$];
  logic signed [15:0] xs[CAP];
  logic signed [15:0] ys[CAP];
  int                 npts;
  bit                 lost;
  logic [THR_W-1:0]   thr;

  function automatic logic [63:0] root_fix(logic [63:0] d2);
    logic [127:0] rad;
    logic [127:0] trial;
    logic [63:0]  root;
    rad  = {64'd0, d2} << (2 * FRAC_BITS_DEF);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = {64'd0, root | (64'd1 << b)};
      if (trial * trial <= rad) root = root | (64'd1 << b);
    end
    return root;
  endfunction

  function automatic logic [63:0] dsq(int i, int j);
    longint dx;
    longint dy;
    dx = longint'(xs[i]) - longint'(xs[j]);
    dy = longint'(ys[i]) - longint'(ys[j]);
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [LEN_W-1:0] round_len(logic [63:0] s);
    logic [63:0] r;
    r = (s + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
    return (r > 64'(2**LEN_W - 1)) ? {LEN_W{1'b1}} : r[LEN_W-1:0];
  endfunction

  function automatic tally_t span_tally();
    logic [63:0] best[CAP];
    bit          joined[CAP];
    logic [63:0] thr_sq;
    logic [63:0] road_s;
    logic [63:0] rail_s;
    logic [63:0] d2;
    int          rails;
    int          pick;
    tally_t      t;
    thr_sq = 64'(thr) * 64'(thr);
    road_s = '0;
    rail_s = '0;
    rails  = 0;
    for (int i = 0; i < npts; i++) begin
      joined[i] = 0;
      best[i]   = dsq(0, i);
    end
    joined[0] = 1;
    for (int k = 1; k < npts; k++) begin
      pick = -1;
      for (int i = 1; i < npts; i++)
        if (!joined[i] && (pick < 0 || best[i] < best[pick])) pick = i;
      joined[pick] = 1;
      d2 = best[pick];
      if (d2 >= thr_sq) begin
        rails++;
        rail_s += root_fix(d2);
      end else begin
        road_s += root_fix(d2);
      end
      for (int i = 1; i < npts; i++)
        if (!joined[i] && dsq(pick, i) < best[i]) best[i] = dsq(pick, i);
    end
    t.groups = GRP_W'(rails + 1);
    t.road   = round_len(road_s);
    t.rail   = round_len(rail_s);
    t.ovf    = lost;
    return t;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tally_t want;
    if (rst) begin
      tally_q.delete();
      npts       = 0;
      lost       = 0;
      thr        = '0;
      fail_count = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (tally_q.size() == 0) begin
          report("unexpected request", 1, 0);
        end else begin
          want = tally_q.pop_front();
          if (res.group_count !== want.groups) report("group_count", res.group_count, want.groups);
          if (res.road_length !== want.road) report("road_length", res.road_length, want.road);
          if (res.railroad_length !== want.rail)
            report("railroad_length", res.railroad_length, want.rail);
          if (res.overflow !== want.ovf) report("overflow", res.overflow, want.ovf);
        end
      end
      if (pt.valid && pt.ready) begin
        if (npts < CAP) begin
          xs[npts] = pt.x_coord;
          ys[npts] = pt.y_coord;
          npts++;
        end else begin
          lost = 1;
        end
        if (pt.last_point) begin
          tally_q.insert(tally_q.size(), span_tally());
          npts = 0;
          lost = 0;
        end
      end
      if (cfg_we) thr = cfg_wdata;
    end
    pending = tally_q.size();
  end

endmodule

// ===== dv/euclidean_mst_threshold_split_tb.sv =====
module euclidean_mst_threshold_split_tb;
  import emst_pkg::*;

  localparam int IDLE_LIMIT = 4000000;

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_we = 0;
  logic [THR_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  int               sent = 0;
  bit               calm = 0;
  int               stall_left = 0;

  emst_in_if  pt_if ();
  emst_out_if res_if ();

  euclidean_mst_threshold_split u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pt        (pt_if),
    .res       (res_if)
  );

  emst_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pt         (pt_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  initial begin
    pt_if.valid      = 0;
    pt_if.x_coord    = '0;
    pt_if.y_coord    = '0;
    pt_if.last_point = 0;
    res_if.ready     = 0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 0;
    end else begin
      res_if.ready <= 1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      pt_if.valid = 0;
      repeat (g) @(negedge clk);
    end
    pt_if.x_coord    = x;
    pt_if.y_coord    = y;
    pt_if.last_point = last;
    pt_if.valid      = 1;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    pt_if.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    drain();
    cfg_we    = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_set(int n, int span);
    int lo;
    int hi;
    logic signed [15:0] x;
    logic signed [15:0] y;
    for (int i = 0; i < n; i++) begin
      if (span == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        lo = int'($urandom_range(0, 65535)) - 32768;
        if (lo > 32767 - span) lo = 32767 - span;
        hi = int'($urandom_range(0, span));
        x = 16'(lo + hi);
        y = 16'(lo + int'($urandom_range(0, span)));
      end
      if ($urandom_range(0, 9) == 0 && i > 0) begin
        x = pt_if.x_coord;
        y = pt_if.y_coord;
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    int sets;
    logic [THR_W-1:0] thr_pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_point(-16'sd32768, 16'sd32767, 1);
    send_point(-16'sd32768, -16'sd32768, 0);
    send_point(16'sd32767, 16'sd32767, 1);
    send_point(16'sd5, 16'sd5, 0);
    send_point(16'sd5, 16'sd5, 0);
    send_point(16'sd5, 16'sd5, 1);
    set_threshold({THR_W{1'b1}});
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd3, 16'sd4, 0);
    send_point(-16'sd32768, 16'sd32767, 1);
    set_threshold(THR_W'(5));
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd3, 16'sd4, 0);
    send_point(16'sd7, 16'sd4, 0);
    send_point(-16'sd1, -16'sd1, 1);

    sets = 0;
    while (sent < 1500) begin
      if (sets % 8 == 0) begin
        case ($urandom_range(0, 4))
          0: thr_pick = '0;
          1: thr_pick = {THR_W{1'b1}};
          2: thr_pick = THR_W'($urandom_range(0, 200));
          3: thr_pick = THR_W'($urandom_range(0, 131071));
          default: thr_pick = THR_W'($urandom_range(1, 40000));
        endcase
        set_threshold(thr_pick);
        calm = ($urandom_range(0, 3) == 0);
      end
      if (sets == 60) begin
        drain();
        send_set(MAX_POINTS_DEF + 6, 400);
      end else begin
        case ($urandom_range(0, 3))
          0: send_set($urandom_range(1, 12), 0);
          1: send_set($urandom_range(2, 12), 300);
          2: send_set($urandom_range(2, 30), 30000);
          default: send_set($urandom_range(1, 6), 8);
        endcase
      end
      sets++;
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/emst_pkg.sv
rtl/emst_if.sv
rtl/emst_ram.sv
rtl/emst_sqrt.sv
rtl/euclidean_mst_threshold_split.sv
dv/emst_checker.sv
dv/euclidean_mst_threshold_split_tb.sv
